// ===== sv/timed_gripper_actuator_sequencer_core_assert.svh =====
// Assertion macros used by the checker file of the gripper sequencer.
`ifndef TIMED_GRIPPER_ACTUATOR_SEQUENCER_CORE_ASSERT_SVH
`define TIMED_GRIPPER_ACTUATOR_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define TGAS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define TGAS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tgas_pkg.sv =====
`default_nettype none

package tgas_pkg;

	// Counter width default, the fixed duration register width and the thrust width
	localparam int TICK_COUNTER_BITS_DEF = 20;
	localparam int DUR_BITS = 20;
	localparam int THRUST_BITS = 16;

	// Register reset values
	localparam logic [THRUST_BITS-1:0] THRUST_THRESHOLD_RST = 16'd6554;
	localparam logic [DUR_BITS-1:0] ACTIVATION_TICKS_RST = 20'd2000;
	localparam logic [DUR_BITS-1:0] REACTIVATION_TICKS_RST = 20'd500;
	localparam logic [DUR_BITS-1:0] REFRESH_PERIOD_TICKS_RST = 20'd60000;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_THRUST_THRESHOLD     = 2'd0,
		REG_ACTIVATION_TICKS     = 2'd1,
		REG_REACTIVATION_TICKS   = 2'd2,
		REG_REFRESH_PERIOD_TICKS = 2'd3
	} reg_index_t;

	// Sequencer phase codes, as shown on the result
	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_INIT_REL  = 3'd1,
		PH_READY     = 3'd2,
		PH_ENGAGING  = 3'd3,
		PH_LANDED    = 3'd4,
		PH_RELEASING = 3'd5,
		PH_REENGAGE  = 3'd6
	} phase_t;

	typedef struct packed {
		logic                   grip_request;
		logic [THRUST_BITS-1:0] thrust_level;
	} tgas_in_t;

	typedef struct packed {
		logic       engage_drive;
		logic       release_drive;
		logic       thrust_reset_pulse;
		logic [2:0] phase_code;
	} tgas_out_t;

	typedef struct packed {
		logic [THRUST_BITS-1:0] thrust_threshold;
		logic [DUR_BITS-1:0]    activation_ticks;
		logic [DUR_BITS-1:0]    reactivation_ticks;
		logic [DUR_BITS-1:0]    refresh_period_ticks;
	} tgas_cfg_t;

endpackage

`default_nettype wire

// ===== sv/tgas_cfg_regs.sv =====
`default_nettype none

module tgas_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire tgas_pkg::reg_index_t          cfg_index,
	input  wire logic [tgas_pkg::DUR_BITS-1:0] cfg_data,
	output tgas_pkg::tgas_cfg_t                cfg
);

	// Write the addressed register on each configuration beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.thrust_threshold     <= tgas_pkg::THRUST_THRESHOLD_RST;
			cfg.activation_ticks     <= tgas_pkg::ACTIVATION_TICKS_RST;
			cfg.reactivation_ticks   <= tgas_pkg::REACTIVATION_TICKS_RST;
			cfg.refresh_period_ticks <= tgas_pkg::REFRESH_PERIOD_TICKS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tgas_pkg::REG_THRUST_THRESHOLD: begin
					cfg.thrust_threshold <= cfg_data[tgas_pkg::THRUST_BITS-1:0];
				end
				tgas_pkg::REG_ACTIVATION_TICKS: begin
					cfg.activation_ticks <= cfg_data;
				end
				tgas_pkg::REG_REACTIVATION_TICKS: begin
					cfg.reactivation_ticks <= cfg_data;
				end
				tgas_pkg::REG_REFRESH_PERIOD_TICKS: begin
					cfg.refresh_period_ticks <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/tgas_seq.sv =====
`default_nettype none

module tgas_seq #(
	parameter int TICK_COUNTER_BITS = tgas_pkg::TICK_COUNTER_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tgas_pkg::tgas_cfg_t cfg,
	input  wire tgas_pkg::tgas_in_t  item,
	input  wire logic                advance,
	output tgas_pkg::tgas_out_t      result
);

	localparam int W = TICK_COUNTER_BITS;
	// Compare width covers both the counter and the duration registers
	localparam int CW = (W > tgas_pkg::DUR_BITS) ? W : tgas_pkg::DUR_BITS;
	localparam logic [W-1:0] CNT_MAX = '1;

	tgas_pkg::phase_t phase_q, phase_d;
	logic [W-1:0]     elapsed_q, elapsed_d, cnt_inc;
	logic             engage_q, engage_d;
	logic             release_q, release_d;
	logic             pulse, restart;
	logic [CW-1:0]    cnt_x, act_x, react_x, refr_x;

	// Work out one tick of the sequencer
	always_comb begin
		cnt_inc   = (elapsed_q == CNT_MAX) ? elapsed_q : elapsed_q + 1'b1;
		cnt_x     = CW'(cnt_inc);
		act_x     = CW'(cfg.activation_ticks);
		react_x   = CW'(cfg.reactivation_ticks);
		refr_x    = CW'(cfg.refresh_period_ticks);
		phase_d   = phase_q;
		engage_d  = engage_q;
		release_d = release_q;
		pulse     = 1'b0;
		restart   = 1'b0;
		unique case (phase_q)
			tgas_pkg::PH_IDLE: begin
				if (item.thrust_level >= cfg.thrust_threshold) begin
					release_d = 1'b1;
					phase_d   = tgas_pkg::PH_INIT_REL;
					restart   = 1'b1;
				end
			end
			tgas_pkg::PH_INIT_REL: begin
				if (cnt_x >= act_x) begin
					release_d = 1'b0;
					phase_d   = tgas_pkg::PH_READY;
				end
			end
			tgas_pkg::PH_READY: begin
				if (item.grip_request) begin
					engage_d = 1'b1;
					phase_d  = tgas_pkg::PH_ENGAGING;
					restart  = 1'b1;
				end
			end
			tgas_pkg::PH_ENGAGING: begin
				if (cnt_x > act_x) begin
					engage_d = 1'b0;
					phase_d  = tgas_pkg::PH_LANDED;
					pulse    = 1'b1;
					restart  = 1'b1;
				end
			end
			tgas_pkg::PH_LANDED: begin
				if (item.grip_request) begin
					engage_d  = 1'b0;
					release_d = 1'b1;
					phase_d   = tgas_pkg::PH_RELEASING;
					restart   = 1'b1;
				end else if (cnt_x > refr_x) begin
					engage_d = 1'b1;
					phase_d  = tgas_pkg::PH_REENGAGE;
					restart  = 1'b1;
				end
			end
			tgas_pkg::PH_RELEASING: begin
				if (cnt_x > act_x) begin
					release_d = 1'b0;
					phase_d   = tgas_pkg::PH_READY;
				end
			end
			tgas_pkg::PH_REENGAGE: begin
				// release only with thrust strictly above the take-off level
				if (item.grip_request && (item.thrust_level > cfg.thrust_threshold)) begin
					engage_d  = 1'b0;
					release_d = 1'b1;
					phase_d   = tgas_pkg::PH_RELEASING;
					restart   = 1'b1;
				end else if (cnt_x > react_x) begin
					engage_d = 1'b0;
					phase_d  = tgas_pkg::PH_LANDED;
					restart  = 1'b1;
				end
			end
			default: begin
			end
		endcase
		elapsed_d = restart ? '0 : cnt_inc;
	end

	assign result.engage_drive       = engage_d;
	assign result.release_drive      = release_d;
	assign result.thrust_reset_pulse = pulse;
	assign result.phase_code         = phase_d;

	// Advance the sequencer state once per tick taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= tgas_pkg::PH_IDLE;
			elapsed_q <= '0;
			engage_q  <= 1'b0;
			release_q <= 1'b0;
		end else if (advance) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			engage_q  <= engage_d;
			release_q <= release_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/timed_gripper_actuator_sequencer_core.sv =====
`default_nettype none

// Gripper actuator sequencer: each input beat is one millisecond tick (grip request and
// thrust sample) and yields exactly one result beat with both drive levels, the thrust
// reset pulse and the phase code after that tick. One tick is taken every clock cycle
// unless the output stalls: a tick sits in the input register while the sequencer logic
// evaluates it against the current state, then the result lands in the output register,
// and the next tick enters as that result is loaded. A stalled output holds the pipe; the
// input register keeps taking ticks while it is empty. Configuration registers are
// written through the cfg port at any time, which is always ready, and take effect on
// the next tick evaluated. The tick counter saturates at 2^TICK_COUNTER_BITS-1.
module timed_gripper_actuator_sequencer_core #(
	parameter int TICK_COUNTER_BITS = tgas_pkg::TICK_COUNTER_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire tgas_pkg::tgas_in_t            in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output tgas_pkg::tgas_out_t                out_data,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire tgas_pkg::reg_index_t          cfg_index,
	input  wire logic [tgas_pkg::DUR_BITS-1:0] cfg_data
);

	tgas_pkg::tgas_cfg_t cfg;
	tgas_pkg::tgas_in_t  item_s1;
	tgas_pkg::tgas_out_t result, out_data_s2;
	logic                valid_s1, out_valid_s2, advance;

	assign cfg_ready = 1'b1;

	tgas_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Move a tick on when the output register is free or being drained
	assign advance  = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	tgas_seq #(
		.TICK_COUNTER_BITS (TICK_COUNTER_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.result  (result)
	);

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_s2 <= result;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

endmodule

`default_nettype wire

// ===== sv/tgas_checker.sv =====
`default_nettype none

`include "timed_gripper_actuator_sequencer_core_assert.svh"

module tgas_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire tgas_pkg::tgas_out_t out_data
);

	// Hold a stalled result beat
	`TGAS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

	// Never drive both actuators at once
	`TGAS_ASSERT_IMP(a_drive_excl, out_valid, !(out_data.engage_drive && out_data.release_drive), "engage and release driven together")

	// Thrust reset pulse only on entry to landed with engage dropped
	`TGAS_ASSERT_IMP(a_pulse_landed, out_valid && out_data.thrust_reset_pulse, (out_data.phase_code == tgas_pkg::PH_LANDED) && !out_data.engage_drive, "thrust reset pulse outside landing")

	// An empty output register never blocks the input
	`TGAS_ASSERT_IMP(a_in_free, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind timed_gripper_actuator_sequencer_core tgas_checker u_tgas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
